@@ sv/eofp_pkg.sv @@
package eofp_pkg;

  // Hard ceiling on any frame length, on top of the programmable limit
  localparam int unsigned MAX_FRAME_BYTES = 65536;
  localparam int unsigned FRAME_W = 17;
  localparam int unsigned OPS_W = 12;

  // Result kinds
  localparam logic [1:0] KIND_OP_HEADER = 2'd0;
  localparam logic [1:0] KIND_TEXT      = 2'd1;
  localparam logic [1:0] KIND_FRAME_END = 2'd2;
  localparam logic [1:0] KIND_TOO_LONG  = 2'd3;

  // Configuration registers
  localparam int unsigned APB_ADDR_W = 3;
  localparam logic [APB_ADDR_W-3:0] REG_FRAME_LIMIT = '0;
  localparam logic [FRAME_W-1:0] FRAME_LIMIT_RESET = FRAME_W'(65536);

  // Queue between parser and result sequencer
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Everything one input byte gives: a first result and optionally a
  // trailing frame end carried in the same entry
  typedef struct packed {
    logic [1:0]         kind;
    logic               second;
    logic [7:0]         op_kind;
    logic [63:0]        op_sequence;
    logic [31:0]        line_number;
    logic [31:0]        column_number;
    logic [FRAME_W-1:0] text_length;
    logic [7:0]         text_byte;
    logic [7:0]         frame_flags;
    logic [63:0]        packet_number;
    logic [OPS_W-1:0]   op_count;
  } run_t;

endpackage

@@ sv/eofp_if.sv @@
interface eofp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface eofp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        last_of_run;
  logic [7:0]  frame_flags;
  logic [63:0] packet_number;
  logic [11:0] op_count;
  logic [7:0]  op_kind;
  logic [63:0] op_sequence;
  logic [31:0] line_number;
  logic [31:0] column_number;
  logic [16:0] text_length;
  logic [7:0]  text_byte;

  modport source (
    output valid, output kind, output last_of_run, output frame_flags,
    output packet_number, output op_count, output op_kind, output op_sequence,
    output line_number, output column_number, output text_length,
    output text_byte, input ready
  );
  modport sink (
    input valid, input kind, input last_of_run, input frame_flags,
    input packet_number, input op_count, input op_kind, input op_sequence,
    input line_number, input column_number, input text_length,
    input text_byte, output ready
  );
endinterface

@@ sv/eofp_front.sv @@
module eofp_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [7:0]                  stream_byte,
  input  logic [eofp_pkg::FRAME_W-1:0] frame_limit,
  output logic                        push,
  output eofp_pkg::run_t              run
);
  import eofp_pkg::*;

  localparam logic [3:0] PH_LEN     = 4'd0;
  localparam logic [3:0] PH_FLAGS   = 4'd1;
  localparam logic [3:0] PH_PKT     = 4'd2;
  localparam logic [3:0] PH_CIDLEN  = 4'd3;
  localparam logic [3:0] PH_CIDSKIP = 4'd4;
  localparam logic [3:0] PH_OPTYPE  = 4'd5;
  localparam logic [3:0] PH_OPSEQ   = 4'd6;
  localparam logic [3:0] PH_OPLINE  = 4'd7;
  localparam logic [3:0] PH_OPCOL   = 4'd8;
  localparam logic [3:0] PH_OPTLEN  = 4'd9;
  localparam logic [3:0] PH_OPTEXT  = 4'd10;
  localparam logic [3:0] PH_DRAIN   = 4'd11;

  localparam logic [FRAME_W-1:0] FRAME_MAX = FRAME_W'(MAX_FRAME_BYTES);
  localparam logic [OPS_W-1:0] OPS_MAX = '1;

  logic [3:0]         phase, phase_next;
  logic [2:0]         cnt, cnt_next;
  logic               halted, halted_next;
  logic [63:0]        shift, shift_next;
  logic [FRAME_W-1:0] frame_left, frame_left_next;
  logic [FRAME_W-1:0] skip, skip_next;
  logic [7:0]         flags, flags_next;
  logic [63:0]        pkt, pkt_next;
  logic [7:0]         opk, opk_next;
  logic [63:0]        seq, seq_next;
  logic [31:0]        line, line_next;
  logic [31:0]        col, col_next;
  logic [OPS_W-1:0]   ops, ops_next;

  logic [63:0]        shifted;
  logic [2:0]         cnt_inc;
  logic [31:0]        len;
  logic [FRAME_W-1:0] limit;
  logic [FRAME_W-1:0] skip_dec;
  logic [OPS_W-1:0]   ops_inc;
  logic               len_fits;

  always_comb begin
    shifted  = {shift[55:0], stream_byte};
    cnt_inc  = cnt + 3'd1;
    len      = shifted[31:0];
    limit    = (frame_limit > FRAME_MAX) ? FRAME_MAX : frame_limit;
    skip_dec = (skip == '0) ? skip : skip - 1'b1;
    ops_inc  = (ops == OPS_MAX) ? ops : ops + 1'b1;
    // fits in what is left after this byte
    len_fits = len < {{(32 - FRAME_W){1'b0}}, frame_left};
  end

  always_comb begin
    phase_next      = phase;
    cnt_next        = cnt;
    halted_next     = halted;
    shift_next      = shift;
    frame_left_next = frame_left;
    skip_next       = skip;
    flags_next      = flags;
    pkt_next        = pkt;
    opk_next        = opk;
    seq_next        = seq;
    line_next       = line;
    col_next        = col;
    ops_next        = ops;
    push            = 1'b0;
    run             = '0;

    if (accept && !halted) begin
      if (phase == PH_LEN) begin
        shift_next = shifted;
        cnt_next   = cnt_inc;
        if (cnt_inc == 3'd4) begin
          cnt_next   = '0;
          shift_next = '0;
          flags_next = '0;
          pkt_next   = '0;
          ops_next   = '0;
          if (len > {{(32 - FRAME_W){1'b0}}, limit}) begin
            push        = 1'b1;
            run.kind    = KIND_TOO_LONG;
            halted_next = 1'b1;
          end else if (len == '0) begin
            push     = 1'b1;
            run.kind = KIND_FRAME_END;
          end else begin
            frame_left_next = len[FRAME_W-1:0];
            phase_next      = PH_FLAGS;
          end
        end
      end else begin
        frame_left_next = frame_left - 1'b1;
        unique case (phase)
          PH_FLAGS: begin
            flags_next = stream_byte;
            phase_next = PH_PKT;
          end
          PH_PKT: begin
            shift_next = shifted;
            cnt_next   = cnt_inc;
            if (cnt_inc == 3'd0) begin
              pkt_next   = shifted;
              phase_next = PH_CIDLEN;
            end
          end
          PH_CIDLEN: begin
            shift_next = shifted;
            cnt_next   = cnt_inc;
            if (cnt_inc == 3'd4) begin
              cnt_next = '0;
              if (!len_fits) begin
                phase_next = PH_DRAIN;
              end else if (len == '0) begin
                phase_next = PH_OPTYPE;
              end else begin
                skip_next  = len[FRAME_W-1:0];
                phase_next = PH_CIDSKIP;
              end
            end
          end
          PH_CIDSKIP: begin
            skip_next = skip_dec;
            if (skip_dec == '0) phase_next = PH_OPTYPE;
          end
          PH_OPTYPE: begin
            opk_next   = stream_byte;
            cnt_next   = '0;
            phase_next = PH_OPSEQ;
          end
          PH_OPSEQ: begin
            shift_next = shifted;
            cnt_next   = cnt_inc;
            if (cnt_inc == 3'd0) begin
              seq_next   = shifted;
              phase_next = PH_OPLINE;
            end
          end
          PH_OPLINE: begin
            shift_next = shifted;
            cnt_next   = cnt_inc;
            if (cnt_inc == 3'd4) begin
              cnt_next   = '0;
              line_next  = len;
              phase_next = PH_OPCOL;
            end
          end
          PH_OPCOL: begin
            shift_next = shifted;
            cnt_next   = cnt_inc;
            if (cnt_inc == 3'd4) begin
              cnt_next   = '0;
              col_next   = len;
              phase_next = PH_OPTLEN;
            end
          end
          PH_OPTLEN: begin
            shift_next = shifted;
            cnt_next   = cnt_inc;
            if (cnt_inc == 3'd4) begin
              cnt_next = '0;
              if (!len_fits) begin
                phase_next = PH_DRAIN;
              end else begin
                push              = 1'b1;
                run.kind          = KIND_OP_HEADER;
                run.op_kind       = opk;
                run.op_sequence   = seq;
                run.line_number   = line;
                run.column_number = col;
                run.text_length   = len[FRAME_W-1:0];
                if (len == '0) begin
                  ops_next   = ops_inc;
                  phase_next = PH_OPTYPE;
                end else begin
                  skip_next  = len[FRAME_W-1:0];
                  phase_next = PH_OPTEXT;
                end
              end
            end
          end
          PH_OPTEXT: begin
            push          = 1'b1;
            run.kind      = KIND_TEXT;
            run.text_byte = stream_byte;
            skip_next     = skip_dec;
            if (skip_dec == '0) begin
              ops_next   = ops_inc;
              phase_next = PH_OPTYPE;
            end
          end
          default: begin
          end
        endcase

        // last byte of the frame: append the frame summary
        if (frame_left == FRAME_W'(1)) begin
          if (push) begin
            run.second = 1'b1;
          end else begin
            run.kind = KIND_FRAME_END;
          end
          push              = 1'b1;
          run.frame_flags   = flags_next;
          run.packet_number = pkt_next;
          run.op_count      = ops_next;
          phase_next        = PH_LEN;
          cnt_next          = '0;
          shift_next        = '0;
          skip_next         = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_LEN;
      cnt    <= '0;
      halted <= 1'b0;
    end else begin
      phase  <= phase_next;
      cnt    <= cnt_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    shift      <= shift_next;
    frame_left <= frame_left_next;
    skip       <= skip_next;
    flags      <= flags_next;
    pkt        <= pkt_next;
    opk        <= opk_next;
    seq        <= seq_next;
    line       <= line_next;
    col        <= col_next;
    ops        <= ops_next;
  end

endmodule

@@ sv/eofp_queue.sv @@
module eofp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  eofp_pkg::run_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output eofp_pkg::run_t head
);
  import eofp_pkg::*;

  run_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full    = count == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

@@ sv/eofp_back.sv @@
module eofp_back (
  input  logic              clk,
  input  logic              rst,
  input  eofp_pkg::run_t    head,
  input  logic              empty,
  output logic              pop,
  eofp_out_if.source        results
);
  import eofp_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic               last_of_run;
    logic [7:0]         frame_flags;
    logic [63:0]        packet_number;
    logic [OPS_W-1:0]   op_count;
    logic [7:0]         op_kind;
    logic [63:0]        op_sequence;
    logic [31:0]        line_number;
    logic [31:0]        column_number;
    logic [FRAME_W-1:0] text_length;
    logic [7:0]         text_byte;
  } res_t;

  logic             out_valid;
  res_t             out_res;
  res_t             res_next;
  logic             pend;
  logic [7:0]       pend_flags;
  logic [63:0]      pend_pkt;
  logic [OPS_W-1:0] pend_ops;
  logic             load;
  logic             is_end;

  assign load   = !out_valid || results.ready;
  assign pop    = load && !pend && !empty;
  assign is_end = head.kind == KIND_FRAME_END;

  always_comb begin
    res_next = '0;
    if (pend) begin
      res_next.kind          = KIND_FRAME_END;
      res_next.last_of_run   = 1'b1;
      res_next.frame_flags   = pend_flags;
      res_next.packet_number = pend_pkt;
      res_next.op_count      = pend_ops;
    end else begin
      res_next.kind          = head.kind;
      res_next.last_of_run   = !head.second;
      res_next.frame_flags   = is_end ? head.frame_flags : '0;
      res_next.packet_number = is_end ? head.packet_number : '0;
      res_next.op_count      = is_end ? head.op_count : '0;
      res_next.op_kind       = head.op_kind;
      res_next.op_sequence   = head.op_sequence;
      res_next.line_number   = head.line_number;
      res_next.column_number = head.column_number;
      res_next.text_length   = head.text_length;
      res_next.text_byte     = head.text_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (load) begin
      out_valid <= pend || !empty;
      if (pend) begin
        pend <= 1'b0;
      end else if (!empty) begin
        pend <= head.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= res_next;
    if (pop) begin
      pend_flags <= head.frame_flags;
      pend_pkt   <= head.packet_number;
      pend_ops   <= head.op_count;
    end
  end

  assign results.valid         = out_valid;
  assign results.kind          = out_res.kind;
  assign results.last_of_run   = out_res.last_of_run;
  assign results.frame_flags   = out_res.frame_flags;
  assign results.packet_number = out_res.packet_number;
  assign results.op_count      = out_res.op_count;
  assign results.op_kind       = out_res.op_kind;
  assign results.op_sequence   = out_res.op_sequence;
  assign results.line_number   = out_res.line_number;
  assign results.column_number = out_res.column_number;
  assign results.text_length   = out_res.text_length;
  assign results.text_byte     = out_res.text_byte;

endmodule

@@ sv/edit_op_frame_parser_top.sv @@
// Path: a byte is decoded combinationally, written to the queue, then registered out.
// Throughput: one stream byte per cycle while the queue has room; one output result
//   per cycle while the sink is ready, so a frame's last byte with a header or text
//   byte plus the frame summary yields two results, absorbed by a four-entry queue.
// Reset (synchronous, active high): parser waits for a frame length, error
//   halt is cleared, queue and output are emptied, frame_limit returns to 65536.
module edit_op_frame_parser_top (
  input  logic                                 clk,
  input  logic                                 rst,
  eofp_in_if.sink                              stream,
  eofp_out_if.source                           results,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [eofp_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import eofp_pkg::*;

  logic [FRAME_W-1:0]      frame_limit;
  logic [APB_ADDR_W-3:0]   reg_index;
  logic                    cfg_write;
  logic                    accept;
  logic                    push;
  run_t                    run;
  logic                    q_full;
  logic                    q_empty;
  logic                    pop;
  run_t                    head;

  // Configuration port: pready held high, one 32-bit word per register.
  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= FRAME_LIMIT_RESET;
    end else if (cfg_write && reg_index == REG_FRAME_LIMIT) begin
      // keep the low 17 bits; writes to unmapped words are dropped
      frame_limit <= pwdata[FRAME_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_FRAME_LIMIT) prdata = {{(32 - FRAME_W){1'b0}}, frame_limit};
  end

  // Accept a byte whenever the queue has room. The parser decides every
  // byte in the cycle it arrives, so one queue slot covers every possible
  // outcome of that byte, including the frame-end summary appended to it.
  // Bytes that arrive after a frame-too-long error are still taken and dropped.
  assign stream.ready = !q_full;
  assign accept       = stream.valid && stream.ready;

  // Front: byte-serial frame and record parser.
  eofp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (stream.stream_byte),
    .frame_limit (frame_limit),
    .push        (push),
    .run         (run)
  );

  // Decouple the parser from a stalling sink.
  eofp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (run),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // Back: unfold each queue entry into one or two registered results.
  eofp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (q_empty),
    .pop     (pop),
    .results (results)
  );

endmodule

@@ tb/sv/edit_op_frame_parser_top_tb.sv @@
`timescale 1ns / 100ps

module edit_op_frame_parser_top_tb;
  import eofp_pkg::*;

  // Byte counts of the fixed parts of a frame and of an op record
  localparam int HEAD_BYTES    = 13;  // flags, packet number, client-id length
  localparam int CID_LEN_POS   = 9;   // offset of the client-id length in the payload
  localparam int OP_HEAD_BYTES = 21;  // type, sequence, line, column, text length
  localparam int TLEN_OFFSET   = 17;  // offset of the text length within a record

  localparam int QUIET_LIMIT   = 2000;  // cycles without any transaction
  localparam int SETTLE_CYCLES = 8;     // pipeline plus output queue, with margin
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_BYTES   = 250;
  localparam int REPORT_MAX    = 10;

  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_FRAME_LIMIT, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_FRAME_LIMIT, 2'b00};
  localparam logic [OPS_W-1:0]      OPS_MAX    = '1;

  typedef enum logic [3:0] {
    ST_LENGTH, ST_FLAGS, ST_PACKET, ST_CID_LEN, ST_CID_SKIP, ST_OP_TYPE,
    ST_OP_SEQ, ST_OP_LINE, ST_OP_COL, ST_OP_TLEN, ST_OP_TEXT, ST_DRAIN
  } parse_state_t;

  // One output record, fields in the order of the result interface
  typedef struct packed {
    logic [1:0]         kind;
    logic               last_of_run;
    logic [7:0]         frame_flags;
    logic [63:0]        packet_number;
    logic [OPS_W-1:0]   op_count;
    logic [7:0]         op_kind;
    logic [63:0]        op_sequence;
    logic [31:0]        line_number;
    logic [31:0]        column_number;
    logic [FRAME_W-1:0] text_length;
    logic [7:0]         text_byte;
  } parse_result_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  eofp_in_if  stream_if ();
  eofp_out_if result_if ();

  edit_op_frame_parser_top dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_if),
    .results (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Records the parser still owes, oldest first
  parse_result_t parsed_records[$];
  int            bad_records;
  int            bytes_sent;
  int            quiet_cycles;

  // Traffic shaping: percentages of idle cycles on each side, plus a long hold
  int            send_idle_pct;
  int            stall_pct;
  bit            hold_rx;

  // Bytes of the frame being assembled (payload only, length is added on send)
  logic [7:0]    payload[$];

  // Parser mirror: configuration and state
  logic [FRAME_W-1:0] lim_reg;
  parse_state_t       parse_st;
  logic [2:0]         fcount;
  logic [63:0]        fshift;
  logic [FRAME_W-1:0] fleft;
  logic [31:0]        sleft;
  logic [7:0]         hflags;
  logic [63:0]        hpkt;
  logic [7:0]         hkind;
  logic [63:0]        hseq;
  logic [31:0]        hline;
  logic [31:0]        hcol;
  logic [OPS_W-1:0]   nops;
  bit                 halted;

  // ------------------------------------------------------------------------
  // Clock
  // ------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Parser mirror
  // ------------------------------------------------------------------------
  function automatic void reset_model();
    lim_reg  = FRAME_LIMIT_RESET;
    parse_st = ST_LENGTH;
    fcount   = '0;
    fshift   = '0;
    fleft    = '0;
    sleft    = '0;
    hflags   = '0;
    hpkt     = '0;
    hkind    = '0;
    hseq     = '0;
    hline    = '0;
    hcol     = '0;
    nops     = '0;
    halted   = 1'b0;
  endfunction

  // Shift a byte into the field register; true once 'need' bytes are in.
  // An 8-byte field wraps the 3-bit count back to zero.
  function automatic bit shift_field(input logic [7:0] b, input int need);
    fshift = {fshift[55:0], b};
    fcount = fcount + 3'd1;
    if (fcount == 3'(need)) begin
      fcount = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic parse_result_t frame_summary();
    parse_result_t r;
    r               = '0;
    r.kind          = KIND_FRAME_END;
    r.frame_flags   = hflags;
    r.packet_number = hpkt;
    r.op_count      = nops;
    return r;
  endfunction

  function automatic void count_op();
    if (nops != OPS_MAX) nops = nops + 1'b1;
  endfunction

  // Advance the mirror by one accepted byte and queue the records it causes
  task automatic parse_byte(input logic [7:0] b);
    parse_result_t run[$];
    parse_result_t r;
    logic [31:0]   len;
    int            cap;
    if (halted) return;
    if (parse_st == ST_LENGTH) begin
      if (shift_field(b, 4)) begin
        len    = fshift[31:0];
        cap    = (lim_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(lim_reg);
        fshift = '0;
        hflags = '0;
        hpkt   = '0;
        nops   = '0;
        if (len > 32'(cap)) begin
          r      = '0;
          r.kind = KIND_TOO_LONG;
          run.insert(run.size(), r);
          halted = 1'b1;
        end else if (len == 0) begin
          run.insert(run.size(), frame_summary());
        end else begin
          fleft    = len[FRAME_W-1:0];
          parse_st = ST_FLAGS;
        end
      end
    end else begin
      if (fleft > 0) fleft = fleft - 1'b1;
      case (parse_st)
        ST_FLAGS: begin
          hflags   = b;
          parse_st = ST_PACKET;
        end
        ST_PACKET: begin
          if (shift_field(b, 8)) begin
            hpkt     = fshift;
            parse_st = ST_CID_LEN;
          end
        end
        ST_CID_LEN: begin
          if (shift_field(b, 4)) begin
            len = fshift[31:0];
            if (len > fleft) parse_st = ST_DRAIN;
            else if (len == 0) parse_st = ST_OP_TYPE;
            else begin
              sleft    = len;
              parse_st = ST_CID_SKIP;
            end
          end
        end
        ST_CID_SKIP: begin
          if (sleft > 0) sleft = sleft - 1;
          if (sleft == 0) parse_st = ST_OP_TYPE;
        end
        ST_OP_TYPE: begin
          hkind    = b;
          fcount   = '0;
          parse_st = ST_OP_SEQ;
        end
        ST_OP_SEQ: begin
          if (shift_field(b, 8)) begin
            hseq     = fshift;
            parse_st = ST_OP_LINE;
          end
        end
        ST_OP_LINE: begin
          if (shift_field(b, 4)) begin
            hline    = fshift[31:0];
            parse_st = ST_OP_COL;
          end
        end
        ST_OP_COL: begin
          if (shift_field(b, 4)) begin
            hcol     = fshift[31:0];
            parse_st = ST_OP_TLEN;
          end
        end
        ST_OP_TLEN: begin
          if (shift_field(b, 4)) begin
            len = fshift[31:0];
            if (len > fleft) begin
              parse_st = ST_DRAIN;
            end else begin
              r               = '0;
              r.kind          = KIND_OP_HEADER;
              r.op_kind       = hkind;
              r.op_sequence   = hseq;
              r.line_number   = hline;
              r.column_number = hcol;
              r.text_length   = len[FRAME_W-1:0];
              run.insert(run.size(), r);
              if (len == 0) begin
                count_op();
                parse_st = ST_OP_TYPE;
              end else begin
                sleft    = len;
                parse_st = ST_OP_TEXT;
              end
            end
          end
        end
        ST_OP_TEXT: begin
          r           = '0;
          r.kind      = KIND_TEXT;
          r.text_byte = b;
          run.insert(run.size(), r);
          if (sleft > 0) sleft = sleft - 1;
          if (sleft == 0) begin
            count_op();
            parse_st = ST_OP_TYPE;
          end
        end
        default: ;
      endcase
      if (fleft == 0) begin
        run.insert(run.size(), frame_summary());
        parse_st = ST_LENGTH;
        fcount   = '0;
        fshift   = '0;
        sleft    = '0;
      end
    end
    if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
    foreach (run[i]) parsed_records.insert(parsed_records.size(), run[i]);
  endtask

  // ------------------------------------------------------------------------
  // Result side: random ready, long hold on request, record comparison
  // ------------------------------------------------------------------------
  always @(negedge clk) begin
    result_if.ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
  end

  function automatic string describe(input parse_result_t r);
    return $sformatf({"kind=%0d last=%0d flags=%02h pkt=%016h ops=%0d op=%02h ",
                      "seq=%016h line=%08h col=%08h tlen=%0d text=%02h"},
                     r.kind, r.last_of_run, r.frame_flags, r.packet_number,
                     r.op_count, r.op_kind, r.op_sequence, r.line_number,
                     r.column_number, r.text_length, r.text_byte);
  endfunction

  // Compare each output transaction with the oldest owed record
  always @(posedge clk) begin : check_records
    parse_result_t got;
    parse_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      got = {result_if.kind, result_if.last_of_run, result_if.frame_flags,
             result_if.packet_number, result_if.op_count, result_if.op_kind,
             result_if.op_sequence, result_if.line_number,
             result_if.column_number, result_if.text_length, result_if.text_byte};
      if (parsed_records.size() == 0) begin
        bad_records++;
        if (bad_records <= REPORT_MAX)
          $display("%0t: record with none owed: %s", $realtime, describe(got));
      end else begin
        want = parsed_records.pop_front();
        if (got !== want) begin
          bad_records++;
          if (bad_records <= REPORT_MAX) begin
            $display("%0t: record mismatch", $realtime);
            $display("  expected %s", describe(want));
            $display("  actual   %s", describe(got));
          end
        end
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long
  always @(posedge clk) begin
    if (rst || (stream_if.valid && stream_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Stream side
  // ------------------------------------------------------------------------
  // Offer one byte after a random idle spell, hold it until taken, then
  // return at the next falling edge with valid still high.
  task automatic push_stream_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      stream_if.valid <= 1'b0;
      @(negedge clk);
    end
    stream_if.valid       <= 1'b1;
    stream_if.stream_byte <= b;
    do @(posedge clk); while (!stream_if.ready);
    parse_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Send a big-endian length, then the payload up to that length, and clear
  // the payload. A short payload is sent whole.
  task automatic send_framed(input logic [31:0] frame_len);
    for (int i = 3; i >= 0; i--) push_stream_byte(frame_len[8*i +: 8]);
    for (int i = 0; i < payload.size() && i < frame_len; i++)
      push_stream_byte(payload[i]);
    payload.delete();
  endtask

  // Drop valid, wait until every owed record is out, then let the pipe settle
  task automatic wait_results_drained();
    stream_if.valid <= 1'b0;
    while (parsed_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ------------------------------------------------------------------------
  // Configuration port
  // ------------------------------------------------------------------------
  task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[APB_ADDR_W-1:2] == REG_FRAME_LIMIT) lim_reg = data[FRAME_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // idle the bus before the next access
    @(negedge clk);
  endtask

  task automatic cfg_read_limit();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(lim_reg)) begin
      bad_records++;
      if (bad_records <= REPORT_MAX)
        $display("%0t: frame_limit read %08h, expected %08h",
                 $realtime, prdata, 32'(lim_reg));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Frame assembly
  // ------------------------------------------------------------------------
  function automatic void add_byte(input logic [7:0] b);
    payload.insert(payload.size(), b);
  endfunction

  function automatic void put_be(input logic [63:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endfunction

  function automatic void patch32(input int pos, input logic [31:0] v);
    for (int i = 0; i < 4; i++) payload[pos+i] = v[8*(3-i) +: 8];
  endfunction

  function automatic logic [63:0] pick64();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void add_head(input logic [7:0] flags, input logic [63:0] pkt,
                                   input logic [31:0] cid_field, input int cid_bytes);
    add_byte(flags);
    put_be(pkt, 8);
    put_be(cid_field, 4);
    repeat (cid_bytes) add_byte(8'($urandom));
  endfunction

  function automatic void add_op(input logic [7:0] op, input logic [63:0] seq,
                                 input logic [31:0] line, input logic [31:0] col,
                                 input logic [31:0] tlen_field, input int text_bytes);
    add_byte(op);
    put_be(seq, 8);
    put_be(line, 4);
    put_be(col, 4);
    put_be(tlen_field, 4);
    repeat (text_bytes) add_byte(8'($urandom));
  endfunction

  // Mostly well-formed frames with random content; the rest overrun the
  // client id or a text, get cut short, or carry noise. Never above the limit.
  task automatic send_random_frame();
    int          cap;
    int          fault;
    int          n_ops;
    int          cid;
    int          tlen;
    int          tlen_pos;
    int          frame_len;
    logic [31:0] over;
    cap      = (lim_reg > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : int'(lim_reg);
    fault    = $urandom_range(99);
    tlen_pos = -1;
    if (fault >= 92) begin
      repeat ($urandom_range(0, 40)) add_byte(8'($urandom));
    end else begin
      cid = $urandom_range(0, 3);
      add_head(8'($urandom), pick64(), cid, cid);
      n_ops = $urandom_range(0, 3);
      repeat (n_ops) begin
        tlen     = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 6);
        tlen_pos = payload.size() + TLEN_OFFSET;
        add_op(8'($urandom), pick64(), 32'(pick64()), 32'(pick64()), tlen, tlen);
      end
    end
    frame_len = payload.size();
    if (fault >= 80 && fault < 92) frame_len = $urandom_range(0, frame_len);
    if (frame_len > cap) frame_len = cap;
    // Overshoot by one now and then, to hit the exact boundary
    over = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF : 32'($urandom_range(1, 3));
    if (fault >= 60 && fault < 70 && frame_len >= HEAD_BYTES)
      patch32(CID_LEN_POS, (over == 32'hFFFF_FFFF) ? over :
              32'(frame_len - HEAD_BYTES) + over);
    if (fault >= 70 && fault < 80 && tlen_pos >= 0 && frame_len >= tlen_pos + 4)
      patch32(tlen_pos, (over == 32'hFFFF_FFFF) ? over :
              32'(frame_len - tlen_pos - 4) + over);
    send_framed(frame_len);
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_register_reset();
    cfg_read_limit();
  endtask

  task automatic test_directed_frames();
    send_idle_pct = 0;
    stall_pct     = 0;
    // Empty frame: summary straight after the length
    send_framed(0);
    // Flags only, packet number missing
    add_byte(8'hA5);
    send_framed(1);
    // Packet number cut after three bytes
    add_byte(8'h01);
    put_be(64'hDEAD_BE, 3);
    send_framed(4);
    // Header only, no client id, no records; all-ones flags and packet
    add_head(8'hFF, '1, 0, 0);
    send_framed(HEAD_BYTES);
    // Client id longer than what is left: drain the rest
    add_head(8'h5A, pick64(), 5, 4);
    send_framed(payload.size());
    // Client id skipped, then an empty-text record on the last byte
    add_head(8'h3C, pick64(), 2, 2);
    add_op(8'h00, '0, '0, '0, 0, 0);
    send_framed(payload.size());
    // All-ones record whose last text byte closes the frame
    add_head(8'hC3, pick64(), 0, 0);
    add_op(8'hFF, '1, '1, '1, 3, 3);
    send_framed(payload.size());
    // Several records in one frame
    add_head(8'h00, pick64(), 1, 1);
    add_op(8'h01, pick64(), 32'd7, 32'd12, 2, 2);
    add_op(8'h02, pick64(), 32'd0, 32'd0, 0, 0);
    add_op(8'h7F, pick64(), 32'h8000_0000, 32'h0000_0001, 1, 1);
    send_framed(payload.size());
    // Record cut short inside its line number
    add_head(8'h11, pick64(), 0, 0);
    add_op(8'h22, pick64(), '1, '1, 4, 4);
    send_framed(HEAD_BYTES + 10);
    // Record cut short inside its text length
    add_head(8'h12, pick64(), 0, 0);
    add_op(8'h23, pick64(), '1, '1, 4, 4);
    send_framed(HEAD_BYTES + OP_HEAD_BYTES - 2);
    // Text one byte longer than the frame holds
    add_head(8'h33, pick64(), 0, 0);
    add_op(8'h44, pick64(), '0, '1, 4, 3);
    send_framed(payload.size());
    // Text length at its largest encoding
    add_head(8'h55, pick64(), 0, 0);
    add_op(8'h66, pick64(), '1, '0, 32'hFFFF_FFFF, 2);
    send_framed(payload.size());
    // 256-byte frame filled by the client id
    add_head(8'h77, pick64(), 256 - HEAD_BYTES, 256 - HEAD_BYTES);
    send_framed(256);
  endtask

  task automatic test_frame_limits();
    // Limit zero: only empty frames pass
    wait_results_drained();
    cfg_write(LIMIT_ADDR, 32'd0);
    cfg_read_limit();
    send_framed(0);
    send_framed(0);
    // Limit one: a flags-only frame sits on the limit
    wait_results_drained();
    cfg_write(LIMIT_ADDR, 32'd1);
    cfg_read_limit();
    add_byte(8'h80);
    send_framed(1);
    // A write to an unused slot leaves the limit alone
    wait_results_drained();
    cfg_write(SPARE_ADDR, 32'h0000_0005);
    cfg_read_limit();
    add_byte(8'h04);
    send_framed(1);
    // All-ones write: the limit is clamped to the ceiling, an ordinary frame passes
    wait_results_drained();
    cfg_write(LIMIT_ADDR, 32'hFFFF_FFFF);
    cfg_read_limit();
    add_head(8'h80, pick64(), 0, 0);
    add_op(8'($urandom), pick64(), 32'(pick64()), 32'(pick64()), 40, 40);
    send_framed(payload.size());
    wait_results_drained();
    cfg_write(LIMIT_ADDR, 32'(FRAME_LIMIT_RESET));
    cfg_read_limit();
  endtask

  task automatic test_random_traffic();
    int          send_mix[4]  = '{0, 85, 0, 11};
    int          stall_mix[4] = '{0, 0, 85, 11};
    logic [31:0] limit_mix[4] = '{32'd65536, 32'd48, 32'd131071, 32'd29};
    int          start;
    int          frames;
    for (int p = 0; p < 4; p++) begin
      wait_results_drained();
      cfg_write(LIMIT_ADDR, limit_mix[p]);
      cfg_read_limit();
      send_idle_pct = send_mix[p];
      stall_pct     = stall_mix[p];
      start         = bytes_sent;
      frames        = 0;
      while (bytes_sent - start < PHASE_BYTES) begin
        send_random_frame();
        frames++;
        // Now and then pause the stream until every record has come out
        if (p == 3 && frames % 6 == 0) wait_results_drained();
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // Hold the result side for a long stretch while the stream keeps offering
  // bytes, so the output queue fills and the block stalls its input.
  task automatic test_output_hold_off();
    wait_results_drained();
    cfg_write(LIMIT_ADDR, 32'd65536);
    fork
      begin
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
      end
      begin
        do send_random_frame(); while (hold_rx);
        stream_if.valid <= 1'b0;
      end
    join
  endtask

  // Must run last: the block halts until reset, and reset is never repeated
  task automatic test_frame_too_long();
    wait_results_drained();
    cfg_write(LIMIT_ADDR, 32'd131071);
    // One past the clamped ceiling; the trailing bytes must be dropped
    repeat (16) add_byte(8'($urandom));
    send_framed(32'(MAX_FRAME_BYTES) + 32'd1);
  endtask

  // ------------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------------
  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    stream_if.valid       = 1'b0;
    stream_if.stream_byte = '0;
    result_if.ready       = 1'b0;
    hold_rx               = 1'b0;
    send_idle_pct         = 0;
    stall_pct             = 0;
    bad_records           = 0;
    bytes_sent            = 0;
    quiet_cycles          = 0;
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_register_reset();
    test_directed_frames();
    test_frame_limits();
    test_random_traffic();
    test_output_hold_off();
    test_frame_too_long();

    // Let the last records out, then watch for strays
    wait_results_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (bad_records == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/eofp_pkg.sv
sv/eofp_if.sv
sv/eofp_front.sv
sv/eofp_queue.sv
sv/eofp_back.sv
sv/edit_op_frame_parser_top.sv
tb/sv/edit_op_frame_parser_top_tb.sv
